/* rtl/quad_perspective_texcoord_weights_assert.svh */
// ----------------------------------------------------------------------------
// Quad perspective texcoord weights: assertion macros
// Shorthand for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef QUAD_PERSPECTIVE_TEXCOORD_WEIGHTS_ASSERT_SVH
`define QUAD_PERSPECTIVE_TEXCOORD_WEIGHTS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QPTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QPTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qptw_pkg.sv */
// ----------------------------------------------------------------------------
// Quad perspective texcoord weights: package
// Register indexes, result widths and coordinate lane wiring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qptw_pkg;

    typedef enum logic [2:0] {
        CFG_RECT_LEFT      = 3'd0,
        CFG_RECT_TOP       = 3'd1,
        CFG_RECT_WIDTH     = 3'd2,
        CFG_RECT_HEIGHT    = 3'd3,
        CFG_TEX_WIDTH      = 3'd4,
        CFG_TEX_HEIGHT     = 3'd5,
        CFG_PERSPECTIVE_ON = 3'd6
    } t_cfg_idx;

    localparam int OUT_W  = 32;
    localparam int CFG_W  = 32;
    localparam int TEX_W  = 16;
    localparam int EDGE_W = CFG_W + 1;
    localparam int PROD_W = OUT_W + EDGE_W;

    localparam logic [OUT_W-1:0] SAT_VAL = '1;

    // Ratio lanes: left/tex_w, right/tex_w, top/tex_h, bottom/tex_h.
    localparam int RAT_LEFT   = 0;
    localparam int RAT_RIGHT  = 1;
    localparam int RAT_TOP    = 2;
    localparam int RAT_BOTTOM = 3;

    typedef struct packed {
        logic [CFG_W-1:0] rect_left;
        logic [CFG_W-1:0] rect_top;
        logic [CFG_W-1:0] rect_width;
        logic [CFG_W-1:0] rect_height;
        logic [TEX_W-1:0] tex_width;
        logic [TEX_W-1:0] tex_height;
        logic             persp;
    } t_cfg;

    // Coordinate lane j uses weight CRD_WGT[j] and ratio CRD_RAT[j]
    // in the order u0, v0, u1, v1, u2, v2, u3, v3.
    localparam int CRD_WGT [8] = '{0, 0, 1, 1, 2, 2, 3, 3};
    localparam int CRD_RAT [8] = '{RAT_LEFT, RAT_TOP, RAT_LEFT, RAT_BOTTOM,
                                   RAT_RIGHT, RAT_BOTTOM, RAT_RIGHT, RAT_TOP};

endpackage

`default_nettype wire

/* rtl/qptw_smul.sv */
// ----------------------------------------------------------------------------
// Quad perspective texcoord weights: signed multiplier
// Two-stage signed multiply built from four half-width partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qptw_smul #(
    parameter int A_W = 33
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire  signed [A_W-1:0]    i_a,
    input  wire  signed [A_W-1:0]    i_b,
    output logic signed [2*A_W-1:0]  o_p
);

    localparam int H = (A_W + 1) / 2;

    logic [2*H-1:0] w_ma;
    logic [2*H-1:0] w_mb;
    logic [2*H-1:0] r_pp00;
    logic [2*H-1:0] r_pp01;
    logic [2*H-1:0] r_pp10;
    logic [2*H-1:0] r_pp11;
    logic           r_neg;
    logic [4*H-1:0] w_sum;
    logic [2*A_W-1:0] w_mag;

    always_comb begin
        w_ma = i_a[A_W-1] ? (2*H)'(-i_a) : (2*H)'(i_a);
        w_mb = i_b[A_W-1] ? (2*H)'(-i_b) : (2*H)'(i_b);
        w_ma = w_ma & (2*H)'({A_W{1'b1}});
        w_mb = w_mb & (2*H)'({A_W{1'b1}});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp00 <= w_ma[H-1:0] * w_mb[H-1:0];
            r_pp01 <= w_ma[H-1:0] * w_mb[2*H-1:H];
            r_pp10 <= w_ma[2*H-1:H] * w_mb[H-1:0];
            r_pp11 <= w_ma[2*H-1:H] * w_mb[2*H-1:H];
            r_neg  <= i_a[A_W-1] ^ i_b[A_W-1];
        end
    end

    always_comb begin
        w_sum = (4*H)'(r_pp00) + ((4*H)'(r_pp01) << H) + ((4*H)'(r_pp10) << H)
              + ((4*H)'(r_pp11) << (2*H));
        w_mag = w_sum[2*A_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= r_neg ? -$signed(w_mag) : $signed(w_mag);
        end
    end

endmodule

`default_nettype wire

/* rtl/qptw_div.sv */
// ----------------------------------------------------------------------------
// Quad perspective texcoord weights: pipelined divider
// Restoring division, one quotient bit per stage, flagging saturation on overflow, a zero divisor or i_force.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qptw_div #(
    parameter int NUM_W = 96,
    parameter int DEN_W = 64,
    parameter int Q_W   = 32
) (
    input  wire              i_clk,
    input  wire              i_en,
    input  wire              i_force,
    input  wire  [NUM_W-1:0] i_num,
    input  wire  [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_q,
    output logic             o_sat
);

    localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

    logic [CW-1:0]    r_rem [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic             r_sat [0:Q_W];
    logic [CW-1:0]    w_top;
    logic             n_sat;

    always_comb begin
        w_top = CW'(i_den) << Q_W;
        n_sat = i_force || (i_den == '0) || (CW'(i_num) >= w_top);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_sat[0] <= n_sat;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        localparam int SH = Q_W - k;
        logic [CW-1:0]  w_sub;
        logic           w_ge;
        logic [CW-1:0]  n_rem;
        logic [Q_W-1:0] n_q;

        always_comb begin
            w_sub = CW'(r_den[k-1]) << SH;
            w_ge  = r_rem[k-1] >= w_sub;
            n_rem = w_ge ? r_rem[k-1] - w_sub : r_rem[k-1];
            n_q   = r_q[k-1] | (w_ge ? (Q_W'(1) << SH) : '0);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= r_den[k-1];
                r_q[k]   <= n_q;
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_q   = r_q[Q_W];
    assign o_sat = r_sat[Q_W];

endmodule

`default_nettype wire

/* rtl/quad_perspective_texcoord_weights.sv */
// ----------------------------------------------------------------------------
// Quad perspective texcoord weights
// Diagonal crossing of a quad, projective corner weights and texture
// coordinates, one quad per beat.
// ----------------------------------------------------------------------------
// The block takes one quad per cycle and returns its result after the
// difference, multiply, combine and absolute value stages, the divider stages
// for the 32 quotient bits in the four weight divider lanes, then the eight
// coordinate multiplier lanes and the output register.
// Throughput is one quad per cycle whenever the output is taken; a stalled
// output holds the whole pipeline and a one-entry input buffer takes one more
// beat. Configuration must only be written while no quad is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "quad_perspective_texcoord_weights_assert.svh"

module quad_perspective_texcoord_weights
    import qptw_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [2:0]                   i_cfg_index,
    input  wire  [CFG_W-1:0]             i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  signed [COORD_WIDTH-1:0] i_corner0_x,
    input  wire  signed [COORD_WIDTH-1:0] i_corner0_y,
    input  wire  signed [COORD_WIDTH-1:0] i_corner1_x,
    input  wire  signed [COORD_WIDTH-1:0] i_corner1_y,
    input  wire  signed [COORD_WIDTH-1:0] i_corner2_x,
    input  wire  signed [COORD_WIDTH-1:0] i_corner2_y,
    input  wire  signed [COORD_WIDTH-1:0] i_corner3_x,
    input  wire  signed [COORD_WIDTH-1:0] i_corner3_y,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [OUT_W-1:0]             o_weight0,
    output logic [OUT_W-1:0]             o_weight1,
    output logic [OUT_W-1:0]             o_weight2,
    output logic [OUT_W-1:0]             o_weight3,
    output logic [OUT_W-1:0]             o_tex0_u,
    output logic [OUT_W-1:0]             o_tex0_v,
    output logic [OUT_W-1:0]             o_tex1_u,
    output logic [OUT_W-1:0]             o_tex1_v,
    output logic [OUT_W-1:0]             o_tex2_u,
    output logic [OUT_W-1:0]             o_tex2_v,
    output logic [OUT_W-1:0]             o_tex3_u,
    output logic [OUT_W-1:0]             o_tex3_v
);

    localparam int W       = COORD_WIDTH;
    localparam int AW      = W + 1;
    localparam int PW      = 2 * AW;
    localparam int NW      = PW + 1;
    localparam int EW      = PW + 2;
    localparam int SW      = EW + 1 + FRAC_BITS;
    localparam int DIV_LAT = OUT_W + 1;
    localparam int PIPE    = 6 + DIV_LAT + 1;
    localparam logic [OUT_W-1:0] ONE_VAL = OUT_W'(1) << FRAC_BITS;

    // Configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_left   <= '0;
            r_cfg.rect_top    <= '0;
            r_cfg.rect_width  <= '0;
            r_cfg.rect_height <= '0;
            r_cfg.tex_width   <= TEX_W'(1);
            r_cfg.tex_height  <= TEX_W'(1);
            r_cfg.persp       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RECT_LEFT:      r_cfg.rect_left   <= i_cfg_data;
                CFG_RECT_TOP:       r_cfg.rect_top    <= i_cfg_data;
                CFG_RECT_WIDTH:     r_cfg.rect_width  <= i_cfg_data;
                CFG_RECT_HEIGHT:    r_cfg.rect_height <= i_cfg_data;
                CFG_TEX_WIDTH:      r_cfg.tex_width   <= i_cfg_data[TEX_W-1:0];
                CFG_TEX_HEIGHT:     r_cfg.tex_height  <= i_cfg_data[TEX_W-1:0];
                CFG_PERSPECTIVE_ON: r_cfg.persp       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [EDGE_W-1:0] w_right;
    logic [EDGE_W-1:0] w_bottom;

    assign w_right  = EDGE_W'(r_cfg.rect_left) + EDGE_W'(r_cfg.rect_width);
    assign w_bottom = EDGE_W'(r_cfg.rect_top) + EDGE_W'(r_cfg.rect_height);

    // Input buffer and pipeline control
    logic                 r_skid_valid;
    logic signed [W-1:0]  r_skid [8];
    logic signed [W-1:0]  w_in   [8];
    logic signed [W-1:0]  w_src  [8];
    logic                 w_in_acc;
    logic                 w_adv;
    logic                 w_src_valid;
    logic [PIPE-1:0]      r_vld;
    logic                 r_out_valid;

    assign w_in = '{i_corner0_x, i_corner0_y, i_corner1_x, i_corner1_y,
                    i_corner2_x, i_corner2_y, i_corner3_x, i_corner3_y};

    assign o_in_ready  = !r_skid_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_adv       = !r_out_valid || i_out_ready;
    assign w_src_valid = r_skid_valid || w_in_acc;
    assign o_out_valid = r_out_valid;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_src[k] = r_skid_valid ? r_skid[k] : w_in[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_skid_valid <= 1'b0;
                r_vld        <= {r_vld[PIPE-2:0], w_src_valid};
                r_out_valid  <= r_vld[PIPE-1];
            end else if (w_in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && w_in_acc) begin
            r_skid <= w_in;
        end
    end

    // Diagonal and offset vectors
    logic signed [AW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ax <= AW'(w_src[4]) - AW'(w_src[0]);
            r_ay <= AW'(w_src[5]) - AW'(w_src[1]);
            r_bx <= AW'(w_src[6]) - AW'(w_src[2]);
            r_by <= AW'(w_src[7]) - AW'(w_src[3]);
            r_cx <= AW'(w_src[0]) - AW'(w_src[2]);
            r_cy <= AW'(w_src[1]) - AW'(w_src[3]);
        end
    end

    // Cross products
    logic signed [AW-1:0] w_ma [6];
    logic signed [AW-1:0] w_mb [6];
    logic signed [PW-1:0] w_p  [6];

    assign w_ma = '{r_by, r_bx, r_bx, r_by, r_ax, r_ay};
    assign w_mb = '{r_ax, r_ay, r_cy, r_cx, r_cy, r_cx};

    for (genvar m = 0; m < 6; m++) begin : g_mul
        qptw_smul #(
            .A_W (AW)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_ma[m]),
            .i_b   (w_mb[m]),
            .o_p   (w_p[m])
        );
    end

    logic signed [NW-1:0] r_d, r_na, r_nb;
    logic signed [EW-1:0] r_ea, r_eb;
    logic [NW-1:0]        r_na_abs, r_nb_abs, r_na_mag, r_nb_mag;
    logic [EW-1:0]        r_ea_mag, r_eb_mag;
    logic [SW-1:0]        r_sa, r_sb;
    logic                 r_dz5, r_dz6;
    logic [EW-1:0]        w_ea_abs, w_eb_abs;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d  <= NW'(w_p[0]) - NW'(w_p[1]);
            r_na <= NW'(w_p[2]) - NW'(w_p[3]);
            r_nb <= NW'(w_p[4]) - NW'(w_p[5]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ea     <= EW'(r_d) - EW'(r_na);
            r_eb     <= EW'(r_d) - EW'(r_nb);
            r_na_abs <= r_na[NW-1] ? NW'(-r_na) : NW'(r_na);
            r_nb_abs <= r_nb[NW-1] ? NW'(-r_nb) : NW'(r_nb);
            r_dz5    <= (r_d == '0);
        end
    end

    assign w_ea_abs = r_ea[EW-1] ? EW'(-r_ea) : EW'(r_ea);
    assign w_eb_abs = r_eb[EW-1] ? EW'(-r_eb) : EW'(r_eb);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_na_mag <= r_na_abs;
            r_nb_mag <= r_nb_abs;
            r_ea_mag <= w_ea_abs;
            r_eb_mag <= w_eb_abs;
            r_sa     <= (SW'(r_na_abs) + SW'(w_ea_abs)) << FRAC_BITS;
            r_sb     <= (SW'(r_nb_abs) + SW'(w_eb_abs)) << FRAC_BITS;
            r_dz6    <= r_dz5;
        end
    end

    // Weight divider lanes: w0 = Sa/|Ea|, w1 = Sb/|Eb|, w2 = Sa/|Na|, w3 = Sb/|Nb|
    logic [SW-1:0]    w_num [4];
    logic [EW-1:0]    w_den [4];
    logic [OUT_W-1:0] w_q   [4];
    logic             w_qs  [4];
    logic [OUT_W-1:0] w_wgt [4];

    assign w_num = '{r_sa, r_sb, r_sa, r_sb};
    assign w_den = '{r_ea_mag, r_eb_mag, EW'(r_na_mag), EW'(r_nb_mag)};

    for (genvar k = 0; k < 4; k++) begin : g_wdiv
        qptw_div #(
            .NUM_W (SW),
            .DEN_W (EW),
            .Q_W   (OUT_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_force (r_dz6),
            .i_num   (w_num[k]),
            .i_den   (w_den[k]),
            .o_q     (w_q[k]),
            .o_sat   (w_qs[k])
        );
        assign w_wgt[k] = w_qs[k] ? SAT_VAL : w_q[k];
    end

    // Edge ratio lanes, running on the held configuration
    logic [EDGE_W-1:0] w_rnum [4];
    logic [TEX_W-1:0]  w_rden [4];
    logic [EDGE_W-1:0] w_rat  [4];
    logic              w_rs   [4];

    assign w_rnum = '{EDGE_W'(r_cfg.rect_left), w_right, EDGE_W'(r_cfg.rect_top), w_bottom};
    assign w_rden = '{r_cfg.tex_width, r_cfg.tex_width, r_cfg.tex_height, r_cfg.tex_height};

    for (genvar k = 0; k < 4; k++) begin : g_rdiv
        qptw_div #(
            .NUM_W (EDGE_W),
            .DEN_W (TEX_W),
            .Q_W   (EDGE_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (1'b1),
            .i_force (1'b0),
            .i_num   (w_rnum[k]),
            .i_den   (w_rden[k]),
            .o_q     (w_rat[k]),
            .o_sat   (w_rs[k])
        );
    end

    // Coordinate lanes and merge into the output register
    logic [OUT_W-1:0]  r_wgt  [4];
    logic [PROD_W-1:0] r_prod [8];
    logic              r_rsat [8];
    logic [OUT_W-1:0]  w_crd  [8];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wgt <= w_wgt;
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_crd
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_prod[j] <= PROD_W'(w_wgt[CRD_WGT[j]]) * PROD_W'(w_rat[CRD_RAT[j]]);
                r_rsat[j] <= w_rs[CRD_RAT[j]];
            end
        end
        assign w_crd[j] = (r_rsat[j] || (r_prod[j][PROD_W-1:FRAC_BITS+OUT_W] != '0))
                        ? SAT_VAL : r_prod[j][FRAC_BITS+OUT_W-1:FRAC_BITS];
    end

    logic [OUT_W-1:0] w_right_sat;
    logic [OUT_W-1:0] w_bottom_sat;

    assign w_right_sat  = w_right[EDGE_W-1] ? SAT_VAL : w_right[OUT_W-1:0];
    assign w_bottom_sat = w_bottom[EDGE_W-1] ? SAT_VAL : w_bottom[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_cfg.persp) begin
                o_weight0 <= r_wgt[0];
                o_weight1 <= r_wgt[1];
                o_weight2 <= r_wgt[2];
                o_weight3 <= r_wgt[3];
                o_tex0_u  <= w_crd[0];
                o_tex0_v  <= w_crd[1];
                o_tex1_u  <= w_crd[2];
                o_tex1_v  <= w_crd[3];
                o_tex2_u  <= w_crd[4];
                o_tex2_v  <= w_crd[5];
                o_tex3_u  <= w_crd[6];
                o_tex3_v  <= w_crd[7];
            end else begin
                o_weight0 <= ONE_VAL;
                o_weight1 <= ONE_VAL;
                o_weight2 <= ONE_VAL;
                o_weight3 <= ONE_VAL;
                o_tex0_u  <= r_cfg.rect_left;
                o_tex0_v  <= r_cfg.rect_top;
                o_tex1_u  <= r_cfg.rect_left;
                o_tex1_v  <= w_bottom_sat;
                o_tex2_u  <= w_right_sat;
                o_tex2_v  <= w_bottom_sat;
                o_tex3_u  <= w_right_sat;
                o_tex3_v  <= r_cfg.rect_top;
            end
        end
    end

    // Checks
    `QPTW_ASSERT_NEXT(a_skid_kept, i_clk, i_rst_n, r_skid_valid && !w_adv, r_skid_valid, "buffered beat lost while stalled")
    `QPTW_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, w_in_acc && !w_adv, r_skid_valid && !o_in_ready, "stalled beat not buffered")
    `QPTW_ASSERT_NOW(a_flat_weight, i_clk, i_rst_n, o_out_valid && !r_cfg.persp, o_weight0 == ONE_VAL && o_weight3 == ONE_VAL, "flat mode weight is not one")
    `QPTW_ASSERT_NEXT(a_out_source, i_clk, i_rst_n, w_adv && !r_vld[PIPE-1], !o_out_valid, "result without a beat in flight")

endmodule

`default_nettype wire

/* tb/quad_perspective_texcoord_weights_tb.sv */
// ----------------------------------------------------------------------------
// Quad perspective texcoord weights: testbench
// Drives quads through the valid/ready input while the output stalls on a
// pattern of its own. Every beat taken at the output is checked field by field
// against a wide-integer computation of the diagonal crossing, the corner
// weights and the texture coordinates, over several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module quad_perspective_texcoord_weights_tb;
    import qptw_pkg::*;

    localparam logic [2:0]  CFG_UNUSED_IDX = 3'd7;
    localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
    localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          DRAIN_CYCLES   = 60;

    typedef logic [0:7][31:0]  t_quad;
    typedef logic [11:0][31:0] t_quad_res;
    typedef struct packed {
        t_quad c;
        logic  degenerate;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_corner0_x, i_corner0_y, i_corner1_x, i_corner1_y;
    logic [31:0] i_corner2_x, i_corner2_y, i_corner3_x, i_corner3_y;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_weight0, o_weight1, o_weight2, o_weight3;
    logic [31:0] o_tex0_u, o_tex0_v, o_tex1_u, o_tex1_v;
    logic [31:0] o_tex2_u, o_tex2_v, o_tex3_u, o_tex3_v;

    logic [31:0] rect_left, rect_top, rect_width, rect_height;
    logic [15:0] tex_width, tex_height;
    logic        persp_on;

    t_quad_res   expected_q[$];
    int          error_count;
    int          cycle_count;
    int          stall_mode;
    t_quad_res   got;
    t_quad_res   want;

    string field_name [12] = '{"weight0", "weight1", "weight2", "weight3",
                               "tex0_u", "tex0_v", "tex1_u", "tex1_v",
                               "tex2_u", "tex2_v", "tex3_u", "tex3_v"};

    quad_perspective_texcoord_weights u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_corner0_x(i_corner0_x), .i_corner0_y(i_corner0_y),
        .i_corner1_x(i_corner1_x), .i_corner1_y(i_corner1_y),
        .i_corner2_x(i_corner2_x), .i_corner2_y(i_corner2_y),
        .i_corner3_x(i_corner3_x), .i_corner3_y(i_corner3_y),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_weight0(o_weight0), .o_weight1(o_weight1),
        .o_weight2(o_weight2), .o_weight3(o_weight3),
        .o_tex0_u(o_tex0_u), .o_tex0_v(o_tex0_v),
        .o_tex1_u(o_tex1_u), .o_tex1_v(o_tex1_v),
        .o_tex2_u(o_tex2_u), .o_tex2_v(o_tex2_v),
        .o_tex3_u(o_tex3_u), .o_tex3_v(o_tex3_v)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] div_sat(logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        if (den == '0) return SAT32;
        q = num / den;
        return (q[127:32] != '0) ? SAT32 : q[31:0];
    endfunction

    function automatic logic [31:0] tex_coord(logic [31:0] wgt, logic [32:0] edge_px,
                                              logic [15:0] tex_px);
        logic [127:0] ratio;
        logic [127:0] prod;
        if (tex_px == '0) return SAT32;
        ratio = {95'd0, edge_px} / {112'd0, tex_px};
        prod  = ({96'd0, wgt} * ratio) >> 16;
        return (prod[127:32] != '0) ? SAT32 : prod[31:0];
    endfunction

    function automatic logic [127:0] mag(logic signed [127:0] v);
        return v[127] ? -v : v;
    endfunction

    // Exact weights from the crossing ratios of the two diagonals.
    function automatic t_quad_res quad_weights(t_quad c);
        logic signed [127:0] x [4];
        logic signed [127:0] y [4];
        logic signed [127:0] ax, ay, bx, by, cx, cy, d, na, nb;
        logic [127:0]        ea, eb, sa, sb;
        logic [32:0]         right, bottom;
        t_quad_res           r;
        for (int k = 0; k < 4; k++) begin
            x[k] = $signed(c[2*k]);
            y[k] = $signed(c[2*k+1]);
        end
        right  = {1'b0, rect_left} + {1'b0, rect_width};
        bottom = {1'b0, rect_top} + {1'b0, rect_height};
        if (!persp_on) begin
            for (int k = 0; k < 4; k++) r[k] = ONE_Q16;
            r[4]  = rect_left;
            r[5]  = rect_top;
            r[6]  = rect_left;
            r[7]  = bottom[32] ? SAT32 : bottom[31:0];
            r[8]  = right[32] ? SAT32 : right[31:0];
            r[9]  = r[7];
            r[10] = r[8];
            r[11] = rect_top;
            return r;
        end
        ax = x[2] - x[0]; ay = y[2] - y[0];
        bx = x[3] - x[1]; by = y[3] - y[1];
        cx = x[0] - x[1]; cy = y[0] - y[1];
        d  = by * ax - bx * ay;
        if (d == 0) begin
            for (int k = 0; k < 4; k++) r[k] = SAT32;
        end else begin
            na = bx * cy - by * cx;
            nb = ax * cy - ay * cx;
            ea = mag(d - na);
            eb = mag(d - nb);
            sa = (mag(na) + ea) << 16;
            sb = (mag(nb) + eb) << 16;
            r[0] = div_sat(sa, ea);
            r[2] = div_sat(sa, mag(na));
            r[1] = div_sat(sb, eb);
            r[3] = div_sat(sb, mag(nb));
        end
        r[4]  = tex_coord(r[0], {1'b0, rect_left}, tex_width);
        r[5]  = tex_coord(r[0], {1'b0, rect_top}, tex_height);
        r[6]  = tex_coord(r[1], {1'b0, rect_left}, tex_width);
        r[7]  = tex_coord(r[1], bottom, tex_height);
        r[8]  = tex_coord(r[2], right, tex_width);
        r[9]  = tex_coord(r[2], bottom, tex_height);
        r[10] = tex_coord(r[3], right, tex_width);
        r[11] = tex_coord(r[3], {1'b0, rect_top}, tex_height);
        return r;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RECT_LEFT:      rect_left   = data;
            CFG_RECT_TOP:       rect_top    = data;
            CFG_RECT_WIDTH:     rect_width  = data;
            CFG_RECT_HEIGHT:    rect_height = data;
            CFG_TEX_WIDTH:      tex_width   = data[15:0];
            CFG_TEX_HEIGHT:     tex_height  = data[15:0];
            CFG_PERSPECTIVE_ON: persp_on    = data[0];
            default: ;
        endcase
    endtask

    task automatic set_registers(logic [31:0] l, logic [31:0] t, logic [31:0] w,
                                 logic [31:0] h, logic [15:0] tw, logic [15:0] th,
                                 logic p);
        cfg_write(CFG_RECT_LEFT, l);
        cfg_write(CFG_RECT_TOP, t);
        cfg_write(CFG_RECT_WIDTH, w);
        cfg_write(CFG_RECT_HEIGHT, h);
        cfg_write(CFG_TEX_WIDTH, {16'($urandom), tw});
        cfg_write(CFG_TEX_HEIGHT, {16'($urandom), th});
        cfg_write(CFG_PERSPECTIVE_ON, {31'($urandom), p});
        // A write beyond the register list must leave every register alone.
        i_cfg_index <= CFG_UNUSED_IDX;
        i_cfg_data  <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_quad(t_quad c, t_quad_res result);
        i_in_valid  <= 1'b1;
        i_corner0_x <= c[0]; i_corner0_y <= c[1];
        i_corner1_x <= c[2]; i_corner1_y <= c[3];
        i_corner2_x <= c[4]; i_corner2_y <= c[5];
        i_corner3_x <= c[6]; i_corner3_y <= c[7];
        do @(posedge i_clk); while (!o_in_ready);
        expected_q.push_back(result);
    endtask

    function automatic t_quad random_quad();
        t_quad       c;
        logic [31:0] bx, by, s, j;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            bx = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            by = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            s  = $urandom_range(32'h0000_1000, 32'h0040_0000);
            j  = s >> 1;
            c[0] = bx - s + $urandom_range(0, j); c[1] = by - s + $urandom_range(0, j);
            c[2] = bx - s + $urandom_range(0, j); c[3] = by + s - $urandom_range(0, j);
            c[4] = bx + s - $urandom_range(0, j); c[5] = by + s - $urandom_range(0, j);
            c[6] = bx + s - $urandom_range(0, j); c[7] = by - s + $urandom_range(0, j);
        end else if (pick < 80) begin
            for (int k = 0; k < 8; k++) c[k] = $urandom;
        end else if (pick < 90) begin
            for (int k = 0; k < 8; k++) c[k] = $urandom_range(0, 32'h0010_0000);
            if ($urandom_range(0, 1) == 0) begin
                c[4] = c[0]; c[5] = c[1];
            end else begin
                c[6] = c[2] + (c[4] - c[0]) * 2;
                c[7] = c[3] + (c[5] - c[1]) * 2;
            end
        end else begin
            for (int k = 0; k < 8; k++)
                c[k] = 32'($signed($urandom_range(0, 8)) - 4) << 16;
        end
        return c;
    endfunction

    task automatic random_phase(int count);
        t_quad c;
        int    burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
            burst--;
            c = random_quad();
            send_quad(c, quad_weights(c));
        end
        i_in_valid <= 1'b0;
        wait_idle();
    endtask

    // Corner order in each row: c0 x, c0 y, c1 x, c1 y, c2 x, c2 y, c3 x, c3 y.
    t_row directed [14] = '{
        '{{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h0},
          1'b0},
        '{{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1},
        '{{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1},
        '{{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0},
        '{{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0},
        '{{32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h2_0000,
           32'h0, 32'h2_0000}, 1'b0},
        '{{32'h0, 32'h0, 32'h0, 32'h2_0000, 32'h1_0000, 32'h1_0000,
           32'h2_0000, 32'h0}, 1'b0},
        '{{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h2_0000, 32'h0,
           32'h2_0000, 32'h1_0000}, 1'b1},
        '{{32'h0, 32'h0, 32'h0, 32'h1, 32'h1_0000_0, 32'h1, 32'h1_0000_0, 32'h2},
          1'b0},
        '{{32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 32'h1, 32'h0}, 1'b0},
        '{{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h1_0000,
           32'h1_0000, 32'h1_0000, 32'h1_0000, 32'hFFFF_0000}, 1'b0},
        '{{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
           32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0},
        '{{32'h0, 32'h0, 32'h0, 32'h10_0000, 32'h40_0000, 32'h40_0000,
           32'h1, 32'h0}, 1'b0},
        '{{32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000,
           32'h2_0000, 32'h2_0000}, 1'b1}
    };

    task automatic directed_phase(logic known_only);
        t_quad_res fixed;
        for (int n = 0; n < 14; n++) begin
            for (int k = 0; k < 12; k++)
                fixed[k] = (k < 4) ? (known_only ? ONE_Q16 : SAT32) : 32'h0;
            if (known_only || directed[n].degenerate)
                send_quad(directed[n].c, fixed);
            else
                send_quad(directed[n].c, quad_weights(directed[n].c));
        end
        i_in_valid <= 1'b0;
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_tex3_v, o_tex3_u, o_tex2_v, o_tex2_u, o_tex1_v, o_tex1_u,
                   o_tex0_v, o_tex0_u, o_weight3, o_weight2, o_weight1, o_weight0};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual weight0 %h",
                         $time, o_weight0);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (got[k] !== want[k]) begin
                        $display("%0t: %s expected %h actual %h", $time, field_name[k],
                                 want[k], got[k]);
                        error_count++;
                    end
                end
            end
        end
        if (cycle_count % 200 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom);
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (cycle_count[2:0] != 3'd0);
        endcase
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        stall_mode  = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_RECT_LEFT;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b1;
        {i_corner0_x, i_corner0_y, i_corner1_x, i_corner1_y} = '0;
        {i_corner2_x, i_corner2_y, i_corner3_x, i_corner3_y} = '0;
        rect_left = '0; rect_top = '0; rect_width = '0; rect_height = '0;
        tex_width = 16'd1; tex_height = 16'd1; persp_on = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_phase(1'b1);
        cfg_write(CFG_PERSPECTIVE_ON, 32'd1);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        directed_phase(1'b0);

        set_registers(32'h0, 32'h0, 32'h40_0000, 32'h40_0000, 16'd64, 16'd64, 1'b1);
        random_phase(170);
        set_registers($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 65535),
                      $urandom_range(1, 65535), 1'b1);
        random_phase(170);
        set_registers($urandom, $urandom, $urandom, $urandom, 16'd7, 16'd9, 1'b0);
        random_phase(170);
        set_registers(SAT32, SAT32, SAT32, SAT32, 16'hFFFF, 16'hFFFF, 1'b0);
        random_phase(170);
        set_registers(SAT32, SAT32, SAT32, SAT32, 16'd1, 16'd1, 1'b1);
        random_phase(170);
        set_registers($urandom, $urandom, $urandom, $urandom, 16'd0, 16'd0, 1'b1);
        random_phase(170);
        set_registers($urandom_range(0, 32'h100_0000), $urandom_range(0, 32'h100_0000),
                      $urandom_range(0, 32'h100_0000), $urandom_range(0, 32'h100_0000),
                      $urandom_range(1, 512), $urandom_range(1, 512), 1'b1);
        random_phase(170);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
